// File: rtl/asa_pkg.sv
// ============================================================================
// asa_pkg
// Shared constants, types and GF(16) helpers for the AG syndrome accumulator.
// ============================================================================
package asa_pkg;

    // Number of exponents per coordinate that are accumulated.
    localparam int EXP_COUNT  = 15;
    // Nibble slots per result row; fixed by the result field width.
    localparam int STORE_SIDE = 15;
    localparam int GF_W       = 4;
    localparam int ROW_W      = GF_W * STORE_SIDE;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = $clog2(EXP_COUNT + 1);

    // Multiplicative group order of GF(16).
    localparam logic [4:0] GF_ORDER = 5'd15;

    typedef logic [GF_W-1:0]  t_gf;
    typedef logic [ROW_W-1:0] t_row;

    // One symbol in log form, handed from the log stage to the store.
    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic [EXP_COUNT-1:0][GF_W-1:0] row_log;
        logic [EXP_COUNT-1:0]           row_zero;
        logic [EXP_COUNT-1:0][GF_W-1:0] col_log;
        logic [EXP_COUNT-1:0]           col_zero;
    } t_term;

    // alpha^k for field polynomial x^4+x^3+1, alpha = x.
    function automatic t_gf gf_exp(input t_gf k);
        t_gf v;
        unique case (k)
            4'd0:    v = 4'd1;
            4'd1:    v = 4'd2;
            4'd2:    v = 4'd4;
            4'd3:    v = 4'd8;
            4'd4:    v = 4'd9;
            4'd5:    v = 4'd11;
            4'd6:    v = 4'd15;
            4'd7:    v = 4'd7;
            4'd8:    v = 4'd14;
            4'd9:    v = 4'd5;
            4'd10:   v = 4'd10;
            4'd11:   v = 4'd13;
            4'd12:   v = 4'd3;
            4'd13:   v = 4'd6;
            4'd14:   v = 4'd12;
            default: v = 4'd1;
        endcase
        return v;
    endfunction

    // Discrete log; zero has no log and is flagged separately by the caller.
    function automatic t_gf gf_log(input t_gf v);
        t_gf k;
        unique case (v)
            4'd1:    k = 4'd0;
            4'd2:    k = 4'd1;
            4'd3:    k = 4'd12;
            4'd4:    k = 4'd2;
            4'd5:    k = 4'd9;
            4'd6:    k = 4'd13;
            4'd7:    k = 4'd7;
            4'd8:    k = 4'd3;
            4'd9:    k = 4'd4;
            4'd10:   k = 4'd10;
            4'd11:   k = 4'd5;
            4'd12:   k = 4'd14;
            4'd13:   k = 4'd11;
            4'd14:   k = 4'd8;
            4'd15:   k = 4'd6;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    // (p + q) mod 15 for p, q below 16.
    function automatic t_gf add_mod15(input t_gf p, input t_gf q);
        logic [4:0] s;
        s = {1'b0, p} + {1'b0, q};
        if (s >= GF_ORDER) begin
            s = s - GF_ORDER;
        end
        if (s >= GF_ORDER) begin
            s = s - GF_ORDER;
        end
        return s[GF_W-1:0];
    endfunction

    // (p * q) mod 15; 16 is 1 mod 15, so the high nibble folds onto the low one.
    function automatic t_gf mul_mod15(input t_gf p, input t_gf q);
        logic [7:0] m;
        logic [4:0] f;
        m = {4'd0, p} * {4'd0, q};
        f = {1'b0, m[7:4]} + {1'b0, m[3:0]};
        if (f >= GF_ORDER) begin
            f = f - GF_ORDER;
        end
        return f[GF_W-1:0];
    endfunction

endpackage

// File: rtl/asa_in_if.sv
// ============================================================================
// asa_in_if
// Valid/ready channel carrying one received symbol and its curve point.
// ============================================================================
interface asa_in_if import asa_pkg::*; ();
    logic valid;
    logic ready;
    t_gf  received_value;
    t_gf  point_x;
    t_gf  point_y;
    logic last_symbol;

    modport source (output valid, output received_value, output point_x,
                    output point_y, output last_symbol, input ready);
    modport sink   (input valid, input received_value, input point_x,
                    input point_y, input last_symbol, output ready);
endinterface

// File: rtl/asa_out_if.sv
// ============================================================================
// asa_out_if
// Valid/ready channel carrying one row of packed syndromes.
// ============================================================================
interface asa_out_if import asa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    t_row             row_syndromes;
    logic             last_row;

    modport source (output valid, output row_index, output row_syndromes,
                    output last_row, input ready);
    modport sink   (input valid, input row_index, input row_syndromes,
                    input last_row, output ready);
endinterface

// File: rtl/asa_log_stage.sv
// ============================================================================
// asa_log_stage
// Input register and conversion of one symbol to per-row and per-column logs.
// ============================================================================
module asa_log_stage import asa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    asa_in_if.sink i_in,
    output t_term o_term
);

    logic r_s1_valid;
    logic r_s1_last;
    t_gf  r_s1_e;
    t_gf  r_s1_x;
    t_gf  r_s1_y;

    logic                           r_t_valid;
    logic                           r_t_last;
    logic [EXP_COUNT-1:0][GF_W-1:0] r_t_row_log;
    logic [EXP_COUNT-1:0]           r_t_row_zero;
    logic [EXP_COUNT-1:0][GF_W-1:0] r_t_col_log;
    logic [EXP_COUNT-1:0]           r_t_col_zero;

    logic [EXP_COUNT-1:0][GF_W-1:0] n_row_log;
    logic [EXP_COUNT-1:0]           n_row_zero;
    logic [EXP_COUNT-1:0][GF_W-1:0] n_col_log;
    logic [EXP_COUNT-1:0]           n_col_zero;
    t_gf                            le;
    t_gf                            lx;
    t_gf                            ly;

    assign i_in.ready = i_en;

    // Row a carries log(e * x^a), column b carries log(y^b). A zero base
    // only survives at exponent zero.
    always_comb begin
        le = gf_log(r_s1_e);
        lx = gf_log(r_s1_x);
        ly = gf_log(r_s1_y);
        for (int a = 0; a < EXP_COUNT; a++) begin
            n_row_log[a]  = add_mod15(le, mul_mod15(GF_W'(a), lx));
            n_row_zero[a] = (r_s1_e == '0) || ((r_s1_x == '0) && (a != 0));
            n_col_log[a]  = mul_mod15(GF_W'(a), ly);
            n_col_zero[a] = (r_s1_y == '0) && (a != 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_t_valid  <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_in.valid;
            r_t_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_last    <= i_in.last_symbol;
            r_s1_e       <= i_in.received_value;
            r_s1_x       <= i_in.point_x;
            r_s1_y       <= i_in.point_y;
            r_t_last     <= r_s1_last;
            r_t_row_log  <= n_row_log;
            r_t_row_zero <= n_row_zero;
            r_t_col_log  <= n_col_log;
            r_t_col_zero <= n_col_zero;
        end
    end

    assign o_term.valid    = r_t_valid;
    assign o_term.last     = r_t_last;
    assign o_term.row_log  = r_t_row_log;
    assign o_term.row_zero = r_t_row_zero;
    assign o_term.col_log  = r_t_col_log;
    assign o_term.col_zero = r_t_col_zero;

endmodule

// File: rtl/asa_store.sv
// ============================================================================
// asa_store
// Syndrome cell array: every cell adds its term for each valid symbol, cleared as the last one hands the set out.
// ============================================================================
module asa_store import asa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_term                      i_term,
    output logic                       o_load,
    output logic [EXP_COUNT-1:0][ROW_W-1:0] o_snap
);

    t_gf r_store [EXP_COUNT][EXP_COUNT];
    t_gf n_store [EXP_COUNT][EXP_COUNT];

    // Each cell is independent: term = alpha^(row_log + col_log) unless zero.
    always_comb begin
        for (int a = 0; a < EXP_COUNT; a++) begin
            for (int b = 0; b < EXP_COUNT; b++) begin
                if (i_term.row_zero[a] || i_term.col_zero[b]) begin
                    n_store[a][b] = r_store[a][b];
                end else begin
                    n_store[a][b] = r_store[a][b]
                                  ^ gf_exp(add_mod15(i_term.row_log[a], i_term.col_log[b]));
                end
            end
        end
    end

    always_comb begin
        o_snap = '0;
        for (int a = 0; a < EXP_COUNT; a++) begin
            for (int b = 0; b < EXP_COUNT; b++) begin
                o_snap[a][b*GF_W +: GF_W] = n_store[a][b];
            end
        end
    end

    assign o_load = i_en && i_term.valid && i_term.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < EXP_COUNT; a++) begin
                for (int b = 0; b < EXP_COUNT; b++) begin
                    r_store[a][b] <= '0;
                end
            end
        end else if (i_en && i_term.valid) begin
            for (int a = 0; a < EXP_COUNT; a++) begin
                for (int b = 0; b < EXP_COUNT; b++) begin
                    r_store[a][b] <= i_term.last ? '0 : n_store[a][b];
                end
            end
        end
    end

endmodule

// File: rtl/asa_unload.sv
// ============================================================================
// asa_unload
// Row bank that holds a finished syndrome set and shifts it out row by row.
// ============================================================================
module asa_unload import asa_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [EXP_COUNT-1:0][ROW_W-1:0] i_snap,
    asa_out_if.source                       o_out,
    output logic                            o_free
);

    t_row             r_bank [EXP_COUNT];
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             take;

    assign take = o_out.valid && o_out.ready;

    // The bank can take a new set when it is empty or when its last row leaves in this cycle.
    assign o_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && take);

    assign o_out.valid         = (r_cnt != '0);
    assign o_out.row_index     = r_idx;
    assign o_out.row_syndromes = r_bank[0];
    assign o_out.last_row      = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(EXP_COUNT);
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx <= '0;
            for (int i = 0; i < EXP_COUNT; i++) begin
                r_bank[i] <= i_snap[i];
            end
        end else if (take) begin
            r_idx <= r_idx + IDX_W'(1);
            for (int i = 0; i < EXP_COUNT - 1; i++) begin
                r_bank[i] <= r_bank[i+1];
            end
            r_bank[EXP_COUNT-1] <= '0;
        end
    end

endmodule

// File: rtl/ag_syndrome_accumulator_unit.sv
// ============================================================================
// ag_syndrome_accumulator_unit
// Bivariate syndrome accumulator for an AG code over GF(16), x^4+x^3+1.
// ============================================================================
//
// Channel   Dir   Content per transaction
// i_in      in    received_value, point_x, point_y, last_symbol
// o_out     out   row_index, row_syndromes (15 nibbles), last_row
//
// One symbol is accepted per cycle while the pipeline is not held. A symbol
// passes the input register and the log register and is then added into
// the 15x15 cell array. A symbol marked last moves the finished array into
// the row bank, which sends 15 row transactions, one per cycle while the
// sink is ready, and the array restarts from zero in the same cycle. Reset
// clears the array and all valid state at once. Input stalls only while a
// last symbol waits at the array for the row bank to drain the previous word.
// ============================================================================
module ag_syndrome_accumulator_unit import asa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asa_in_if.sink    i_in,
    asa_out_if.source o_out
);

    t_term                           term;
    logic                            pipe_en;
    logic                            load;
    logic                            bank_free;
    logic [EXP_COUNT-1:0][ROW_W-1:0] snap;

    // The whole pipeline holds when a finished word cannot yet be handed to
    // the row bank; otherwise every stage advances each cycle.
    assign pipe_en = !(term.valid && term.last && !bank_free);

    // Input register plus log-domain expansion of e*x^a and y^b.
    asa_log_stage u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_in    (i_in),
        .o_term  (term)
    );

    // Cell array: each syndrome XORs in its own term.
    asa_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_term  (term),
        .o_load  (load),
        .o_snap  (snap)
    );

    // Output row bank; row_syndromes comes straight from a register.
    asa_unload u_unload (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_snap  (snap),
        .o_out   (o_out),
        .o_free  (bank_free)
    );

endmodule

// File: rtl/asa_checker.sv
// ============================================================================
// asa_checker
// Port-level checks of the row output of the syndrome accumulator.
// ============================================================================
module asa_checker import asa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] i_row_index,
    input t_row             i_row_syndromes,
    input logic             i_last_row
);

    // A stalled row transaction keeps its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_row_index) && $stable(i_row_syndromes)
             && $stable(i_last_row)))
        else $error("row output changed while stalled");

    // Rows of one word leave back to back without gaps in the index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_row) |=>
            (i_out_valid && (i_row_index == $past(i_row_index) + IDX_W'(1))))
        else $error("row sequence broken");

    // The final row flag sits exactly on the highest exponent.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_last_row == (i_row_index == IDX_W'(EXP_COUNT - 1))))
        else $error("last row flag misplaced");

    // A word that directly follows the last row of the previous one starts at row zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last_row) |=>
            (!i_out_valid || (i_row_index == '0)))
        else $error("word does not start at row zero");

    // Reset leaves no row pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("row valid after reset");

endmodule

bind ag_syndrome_accumulator_unit asa_checker u_asa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_row_index     (o_out.row_index),
    .i_row_syndromes (o_out.row_syndromes),
    .i_last_row      (o_out.last_row)
);

// File: bench/ag_syndrome_accumulator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ag_syndrome_accumulator_unit_tb
// Self-checking bench for the GF(16) bivariate syndrome accumulator. Symbols
// are sent over the input channel with random gaps. A behavioral copy of the
// 15x15 syndrome array predicts every row, and each row that leaves the block
// is checked field by field against the oldest prediction.
// ============================================================================
module ag_syndrome_accumulator_unit_tb;
    import asa_pkg::*;

    // x^4 + x^3 + 1, with the x^4 term kept so it can cancel the carry.
    localparam logic [4:0] FIELD_POLY = 5'h19;
    // Cycles without any transaction before the run is declared hung. The
    // longest legal quiet stretch is the receiver hold-off plus a few gaps.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    // Input register, log stage, array, then one row per cycle while the receiver is ready.
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_SYMBOLS = 330;

    // One row of syndromes as the block should present it.
    typedef struct {
        logic [IDX_W-1:0] row_index;
        t_row             row_syndromes;
        logic             last_row;
    } t_syndrome_row;

    logic i_clk;
    logic i_rst_n;

    asa_in_if  in_ch ();
    asa_out_if out_ch ();

    ag_syndrome_accumulator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Behavioral copy of the syndrome array, and the rows that it has
    // produced but the block has not yet delivered.
    t_gf           syndrome_sums [EXP_COUNT][EXP_COUNT];
    t_syndrome_row awaited_rows[$];

    int  error_count = 0;
    int  symbols_sent = 0;
    // Idling switches for each side, and the receiver hold-off request.
    bit  src_idle = 1'b1;
    bit  sink_idle = 1'b1;
    int  sink_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Shift-and-add multiply in GF(16), reducing whenever bit 4 appears.
    function automatic t_gf gf_mul(input t_gf p, input t_gf q);
        logic [4:0] shifted;
        t_gf        acc;
        acc     = '0;
        shifted = {1'b0, p};
        for (int i = 0; i < GF_W; i++) begin
            if (q[i]) begin
                acc ^= shifted[GF_W-1:0];
            end
            shifted = shifted << 1;
            if (shifted[4]) begin
                shifted ^= FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // Adds e * x^a * y^b into every cell. Powers are built by repeated
    // multiplication starting from one, so a zero coordinate contributes only
    // through its zeroth power. On the final symbol of a word the finished
    // array becomes one expected row per x exponent and starts over at zero.
    function automatic void accumulate_symbol(input t_gf e, input t_gf px,
                                              input t_gf py, input logic last);
        t_gf           x_pow;
        t_gf           y_pow;
        t_gf           ex;
        t_syndrome_row row;
        x_pow = 4'd1;
        for (int a = 0; a < EXP_COUNT; a++) begin
            ex    = gf_mul(e, x_pow);
            y_pow = 4'd1;
            for (int b = 0; b < EXP_COUNT; b++) begin
                syndrome_sums[a][b] ^= gf_mul(ex, y_pow);
                y_pow = gf_mul(y_pow, py);
            end
            x_pow = gf_mul(x_pow, px);
        end
        if (last) begin
            for (int a = 0; a < EXP_COUNT; a++) begin
                row.row_index     = a[IDX_W-1:0];
                row.row_syndromes = '0;
                for (int b = 0; b < EXP_COUNT; b++) begin
                    row.row_syndromes[GF_W*b +: GF_W] = syndrome_sums[a][b];
                    syndrome_sums[a][b] = '0;
                end
                row.last_row = (a == EXP_COUNT - 1);
                awaited_rows.push_back(row);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one symbol, after a random gap when idling is on, and returns at
    // the clock edge where the transaction happens. The prediction is made at
    // that edge, so it follows the order in which the block takes symbols.
    task automatic send_symbol(input t_gf e, input t_gf px, input t_gf py,
                               input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.received_value <= e;
        in_ch.point_x        <= px;
        in_ch.point_y        <= py;
        in_ch.last_symbol    <= last;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        accumulate_symbol(e, px, py, last);
        symbols_sent++;
    endtask

    // Coordinates lean toward zero now and then, since zero powers are the
    // only place where the arithmetic takes a different path.
    function automatic t_gf random_coord();
        return ($urandom_range(0, 5) == 0) ? 4'd0 : t_gf'($urandom_range(0, 15));
    endfunction

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    task automatic check_row();
        t_syndrome_row want;
        if (awaited_rows.size() == 0) begin
            $error("unexpected row transaction: row_index %0d", out_ch.row_index);
            error_count++;
        end else begin
            want = awaited_rows.pop_front();
            if (out_ch.row_index !== want.row_index) begin
                $error("row_index: expected %0d, actual %0d",
                       want.row_index, out_ch.row_index);
                error_count++;
            end
            if (out_ch.row_syndromes !== want.row_syndromes) begin
                $error("row_syndromes: expected %h, actual %h",
                       want.row_syndromes, out_ch.row_syndromes);
                error_count++;
            end
            if (out_ch.last_row !== want.last_row) begin
                $error("last_row: expected %0b, actual %0b",
                       want.last_row, out_ch.last_row);
                error_count++;
            end
        end
    endtask

    // Receiver. After every row it draws a number of cycles to hold ready low.
    // A hold-off request overrides that and keeps ready low for the whole
    // stretch, counted here so that the sender keeps pushing meanwhile.
    initial begin : row_sink
        int wait_left;
        wait_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                check_row();
                wait_left = sink_idle ? $urandom_range(0, 6) : 0;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A word made of zero symbols leaves the array untouched, but the last
    // symbol must still produce fifteen rows, all zero.
    task automatic test_zero_symbol_words();
        send_symbol(4'd0, 4'd0, 4'd0, 1'b1);
        send_symbol(4'd0, 4'd15, 4'd7, 1'b0);
        send_symbol(4'd0, 4'd9, 4'd0, 1'b1);
    endtask

    // Field extremes, zero coordinates on either axis and on both, and a zero
    // symbol in the middle of a word with nonzero content around it.
    task automatic test_field_extremes();
        send_symbol(4'd15, 4'd15, 4'd15, 1'b0);
        send_symbol(4'd1,  4'd0,  4'd0,  1'b0);
        send_symbol(4'd15, 4'd0,  4'd7,  1'b0);
        send_symbol(4'd9,  4'd3,  4'd0,  1'b0);
        send_symbol(4'd0,  4'd5,  4'd6,  1'b0);
        send_symbol(4'd15, 4'd1,  4'd1,  1'b1);
        // Single-symbol words: one full set of powers each.
        send_symbol(4'd1,  4'd2,  4'd2,  1'b1);
        send_symbol(4'd15, 4'd15, 4'd15, 1'b1);
        send_symbol(4'd8,  4'd0,  4'd12, 1'b1);
        send_symbol(4'd6,  4'd11, 4'd0,  1'b1);
    endtask

    // Back-to-back short words while the receiver refuses everything. The row
    // bank fills, the array fills behind it, and the next last symbol has to
    // wait at the array until the hold-off ends.
    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_hold = HOLD_CYCLES;
        for (int w = 0; w < 4; w++) begin
            send_symbol(t_gf'($urandom_range(1, 15)), random_coord(), random_coord(),
                        1'b0);
            send_symbol(t_gf'($urandom_range(0, 15)), random_coord(), random_coord(),
                        1'b1);
        end
        src_idle = 1'b1;
    endtask

    // Words of random length and content. Idling on each side is switched per
    // word so that some words stream with no gaps at all.
    task automatic test_random_words();
        int stop_at;
        int word_len;
        stop_at = symbols_sent + RANDOM_SYMBOLS;
        while (symbols_sent < stop_at) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            word_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                     : $urandom_range(1, 10);
            for (int i = 0; i < word_len; i++) begin
                send_symbol(t_gf'($urandom_range(0, 15)), random_coord(),
                            random_coord(), i == word_len - 1);
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        for (int a = 0; a < EXP_COUNT; a++) begin
            for (int b = 0; b < EXP_COUNT; b++) begin
                syndrome_sums[a][b] = '0;
            end
        end
        in_ch.valid          <= 1'b0;
        in_ch.received_value <= '0;
        in_ch.point_x        <= '0;
        in_ch.point_y        <= '0;
        in_ch.last_symbol    <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_symbol_words();
        test_field_extremes();
        test_backpressure();
        test_random_words();

        // The last transaction was just taken; drop valid and let the rows
        // that are still in flight come out.
        in_ch.valid <= 1'b0;
        while (awaited_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/asa_pkg.sv
rtl/asa_in_if.sv
rtl/asa_out_if.sv
rtl/asa_log_stage.sv
rtl/asa_store.sv
rtl/asa_unload.sv
rtl/ag_syndrome_accumulator_unit.sv
rtl/asa_checker.sv
bench/ag_syndrome_accumulator_unit_tb.sv
